[hw/rtl/first_fit_block_allocator_defines.svh]
// Assertion helpers for the allocator, clocked on i_clk, quiet during reset
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define FFBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

[hw/rtl/ffba_pkg.sv]
package ffba_pkg;

    // Heap layout
    localparam int GRAN_BYTES = 8;
    localparam int HDR_BYTES  = 4;
    // Rounded granule count of an 11-bit request: (2047 + 11) >> 3 needs 9 bits
    localparam int NEED_W     = 9;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADITEM = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [10:0] request_bytes;
        logic [8:0]  item_number;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] block_offset;
        logic [11:0] block_size;
    } t_out;

endpackage

[hw/rtl/first_fit_block_allocator.sv]
// Channel  | Direction | Handshake                | Beat
// ---------+-----------+--------------------------+--------------------------------
// command  | in        | i_in_valid / o_in_ready  | i_in_data  (cmd, request, item)
// result   | out       | o_out_valid / i_out_ready| o_out_data (status, offset, size)
//
// Each block visited on the walk goes through the read, check and step states,
// using the header memory and the shared adder; a command visits at most
// HEAP_BYTES / 8 blocks.
// Reset is synchronous; only entry 0 is forced to the whole-heap free block,
// so there is no clearing pass and commands are taken from the first cycle.
// A result waits in the output register; the walker holds its last state
// while that register is full and o_in_ready stays low until the walk ends.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES = 2048
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int GRANULES = HEAP_BYTES / GRAN_BYTES;
    localparam int GW       = $clog2(GRANULES);
    localparam int EW       = GW + 2;

    logic          done_valid;
    logic          done_ready;
    t_out          walk_res;
    logic          rd_en;
    logic [GW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [GW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          r_out_valid;
    t_out          r_out_data;
    logic          out_failed;
    logic          out_fields_zero;

    ffba_walker #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_cmd       (i_in_data),
        .o_done_valid(done_valid),
        .i_done_ready(done_ready),
        .o_res       (walk_res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    ffba_store #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    // Output register between the walker and the result channel
    assign done_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_valid && done_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_valid && done_ready) begin
            r_out_data <= walk_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Flags for the result checks
    assign out_failed      = o_out_valid && (o_out_data.status != ST_OK);
    assign out_fields_zero = (o_out_data.block_offset == '0) && (o_out_data.block_size == '0);

    // A command in flight keeps the input side closed
    `FFBA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // Failed commands report an empty block
    `FFBA_ASSERT_NOW(a_fail_zero, out_failed, out_fields_zero)
    // Headers sit on granule boundaries
    `FFBA_ASSERT_NOW(a_offset_aligned, o_out_valid, o_out_data.block_offset[2:0] == 3'd0)

endmodule

[hw/rtl/ffba_store.sv]
module ffba_store
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES = 2048
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_rd_en,
    input  logic [$clog2(HEAP_BYTES / GRAN_BYTES)-1:0]   i_rd_addr,
    output logic [$clog2(HEAP_BYTES / GRAN_BYTES)+1:0]   o_rd_data,
    input  logic                                         i_wr_en,
    input  logic [$clog2(HEAP_BYTES / GRAN_BYTES)-1:0]   i_wr_addr,
    input  logic [$clog2(HEAP_BYTES / GRAN_BYTES)+1:0]   i_wr_data
);

    localparam int GRANULES = HEAP_BYTES / GRAN_BYTES;
    localparam int GW       = $clog2(GRANULES);
    localparam int LW       = GW + 1;
    localparam int EW       = LW + 1;
    localparam logic [EW-1:0] FIRST_HDR = {LW'(GRANULES), 1'b0};

    logic [EW-1:0] mem [GRANULES];
    logic [EW-1:0] r_rd_data;
    logic          r_fresh;
    logic          r_rd_fresh;

    // Header memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Entry 0 reads as the whole-heap free block until first written.
    // Only block starts are ever read, and every other start is written first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= 1'b1;
            r_rd_fresh <= 1'b0;
        end else begin
            if (i_wr_en && i_wr_addr == '0) begin
                r_fresh <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_fresh <= r_fresh && (i_rd_addr == '0);
            end
        end
    end

    assign o_rd_data = r_rd_fresh ? FIRST_HDR : r_rd_data;

endmodule

[hw/rtl/ffba_walker.sv]
module ffba_walker
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES = 2048
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  t_in                                          i_cmd,
    output logic                                         o_done_valid,
    input  logic                                         i_done_ready,
    output t_out                                         o_res,
    output logic                                         o_rd_en,
    output logic [$clog2(HEAP_BYTES / GRAN_BYTES)-1:0]   o_rd_addr,
    input  logic [$clog2(HEAP_BYTES / GRAN_BYTES)+1:0]   i_rd_data,
    output logic                                         o_wr_en,
    output logic [$clog2(HEAP_BYTES / GRAN_BYTES)-1:0]   o_wr_addr,
    output logic [$clog2(HEAP_BYTES / GRAN_BYTES)+1:0]   o_wr_data
);

    localparam int GRANULES = HEAP_BYTES / GRAN_BYTES;
    localparam int GW       = $clog2(GRANULES);
    localparam int LW       = GW + 1;
    localparam int EW       = LW + 1;
    localparam int AW       = ((LW > NEED_W) ? LW : NEED_W) + 1;
    localparam int XW       = ((LW + 3) > 12) ? (LW + 3) : 12;
    localparam logic [AW-1:0] GRAN_END = AW'(GRANULES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_STEP,
        S_SPLIT,
        S_DONE
    } t_state;

    t_state            r_state;
    logic              r_cmd;
    logic [NEED_W-1:0] r_need;
    logic [8:0]        r_item;
    logic [8:0]        r_pos;
    logic [LW-1:0]     r_g;
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     r_rem;
    t_out              r_res;

    logic [11:0]       req_sum;
    logic [LW-1:0]     hdr_len;
    logic              hdr_used;
    logic [AW-1:0]     alu_a;
    logic [AW-1:0]     alu_b;
    logic              alu_sub;
    logic [AW:0]       alu_sum;
    logic              fits;
    logic              spare;
    logic [XW-1:0]     g_bytes;
    logic [XW-1:0]     len_bytes;
    logic [XW-1:0]     need_bytes;

    // Header fields of the block just read; a zero length counts as one granule
    assign hdr_used = i_rd_data[0];
    assign hdr_len  = (i_rd_data[EW-1:1] == '0) ? LW'(1) : i_rd_data[EW-1:1];

    // Payload plus header, rounded up to whole granules
    assign req_sum = 12'(i_cmd.request_bytes) + 12'(HDR_BYTES + GRAN_BYTES - 1);

    // Shared adder: block length minus need, next block start, split point
    always_comb begin
        alu_a   = AW'(r_g);
        alu_b   = AW'(r_len);
        alu_sub = 1'b0;
        unique case (r_state)
            S_CHECK: begin
                alu_a   = AW'(hdr_len);
                alu_b   = AW'(r_need);
                alu_sub = 1'b1;
            end
            S_SPLIT: begin
                alu_b = AW'(r_need);
            end
            S_IDLE, S_READ, S_STEP, S_DONE: begin
                alu_b = AW'(r_len);
            end
            default: begin
                alu_b = AW'(r_len);
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW + 1)'(alu_sub);
    // Carry out of the subtraction means length >= need
    assign fits    = alu_sum[AW];
    assign spare   = alu_sum[AW-1:0] != '0;

    assign g_bytes    = XW'(r_g) << 3;
    assign len_bytes  = XW'(hdr_len) << 3;
    assign need_bytes = XW'(r_need) << 3;

    // Memory port drive
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_g[GW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_g[GW-1:0];
        o_wr_data = {LW'(r_need), 1'b1};
        unique case (r_state)
            S_READ: begin
                o_rd_en = (AW'(r_g) < GRAN_END);
            end
            S_CHECK: begin
                if (r_cmd == CMD_ALLOC) begin
                    o_wr_en = !hdr_used && fits;
                end else begin
                    o_wr_en   = !(r_pos < r_item);
                    o_wr_data = {i_rd_data[EW-1:1], 1'b0};
                end
            end
            S_SPLIT: begin
                o_wr_en   = alu_sum[AW-1:0] < GRAN_END;
                o_wr_addr = alu_sum[GW-1:0];
                o_wr_data = {r_rem, 1'b0};
            end
            S_IDLE, S_STEP, S_DONE: begin
                o_wr_en = 1'b0;
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_done_valid = (r_state == S_DONE);
    assign o_res        = r_res;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd.cmd;
                        r_need  <= req_sum[11:3];
                        r_item  <= (i_cmd.item_number == '0) ? 9'd1 : i_cmd.item_number;
                        r_pos   <= 9'd1;
                        r_g     <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (AW'(r_g) < GRAN_END) begin
                        r_state <= S_CHECK;
                    end else begin
                        // walked off the end of the heap
                        r_res.status       <= (r_cmd == CMD_ALLOC) ? ST_NOFIT : ST_BADITEM;
                        r_res.block_offset <= '0;
                        r_res.block_size   <= '0;
                        r_state            <= S_DONE;
                    end
                end
                S_CHECK: begin
                    r_len <= hdr_len;
                    if (r_cmd == CMD_ALLOC) begin
                        if (!hdr_used && fits) begin
                            r_rem              <= alu_sum[LW-1:0];
                            r_res.status       <= ST_OK;
                            r_res.block_offset <= g_bytes[10:0];
                            r_res.block_size   <= need_bytes[11:0];
                            r_state            <= spare ? S_SPLIT : S_DONE;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end else begin
                        if (r_pos < r_item) begin
                            r_pos   <= r_pos + 9'd1;
                            r_state <= S_STEP;
                        end else begin
                            r_res.status       <= ST_OK;
                            r_res.block_offset <= g_bytes[10:0];
                            r_res.block_size   <= len_bytes[11:0];
                            r_state            <= S_DONE;
                        end
                    end
                end
                S_STEP: begin
                    r_g     <= alu_sum[LW-1:0];
                    r_state <= S_READ;
                end
                S_SPLIT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_done_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/tb_first_fit_block_allocator.sv]
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int HEAP_BYTES     = 2048;
    localparam int HEAP_GRANULES  = HEAP_BYTES / GRAN_BYTES;
    localparam int MAX_ITEM       = 511;
    // Longest walk visits one block per granule; allow for it after the last beat
    localparam int QUIET_CYCLES   = 3 * HEAP_GRANULES + 40;
    localparam int WATCHDOG_LIMIT = 8 * QUIET_CYCLES;
    localparam int PHASE_ITEMS    = 470;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    // Shadow heap: block length in granules and used flag, valid at block starts only
    int unsigned heap_granules [HEAP_GRANULES];
    bit          heap_used     [HEAP_GRANULES];

    t_out expected_results[$];
    int   fail_count     = 0;
    int   idle_cycles    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    first_fit_block_allocator #(
        .HEAP_BYTES(HEAP_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Span of the block starting at granule g; a block never covers less than one granule
    function automatic int unsigned span_at(input int unsigned g);
        return (heap_granules[g] == 0) ? 1 : heap_granules[g];
    endfunction

    function automatic int unsigned count_blocks();
        int unsigned g;
        int unsigned n;
        g = 0;
        n = 0;
        while (g < HEAP_GRANULES) begin
            g += span_at(g);
            n++;
        end
        return n;
    endfunction

    // Apply one command to the shadow heap and return the result it should give
    function automatic t_out predict_allocation(input t_in beat);
        t_out        res;
        int unsigned g;
        int unsigned need;
        int unsigned len;
        int unsigned pos;
        int unsigned target;
        res = '0;
        g = 0;
        if (beat.cmd == CMD_ALLOC) begin
            need = (int'(beat.request_bytes) + HDR_BYTES + GRAN_BYTES - 1) / GRAN_BYTES;
            res.status = ST_NOFIT;
            while (g < HEAP_GRANULES) begin
                len = span_at(g);
                if (!heap_used[g] && len >= need) begin
                    heap_granules[g] = need;
                    heap_used[g]     = 1'b1;
                    // split the remainder off as a free block
                    if (len > need && g + need < HEAP_GRANULES) begin
                        heap_granules[g + need] = len - need;
                        heap_used[g + need]     = 1'b0;
                    end
                    res.status       = ST_OK;
                    res.block_offset = 11'(g * GRAN_BYTES);
                    res.block_size   = 12'(need * GRAN_BYTES);
                    return res;
                end
                g += len;
            end
            return res;
        end
        // free: walk to the n-th block, 0 treated as the first
        target = (beat.item_number == 0) ? 1 : beat.item_number;
        pos = 1;
        while (g < HEAP_GRANULES && pos < target) begin
            g += span_at(g);
            pos++;
        end
        if (g >= HEAP_GRANULES) begin
            res.status = ST_BADITEM;
            return res;
        end
        heap_used[g]     = 1'b0;
        res.status       = ST_OK;
        res.block_offset = 11'(g * GRAN_BYTES);
        res.block_size   = 12'(span_at(g) * GRAN_BYTES);
        return res;
    endfunction

    function automatic t_in make_command(input logic cmd, input int unsigned req,
                                         input int unsigned item);
        t_in beat;
        beat.cmd           = cmd;
        beat.request_bytes = 11'(req);
        beat.item_number   = 9'(item);
        return beat;
    endfunction

    // Send one command beat, with a random gap first, and log its expected result
    task automatic send_command(input t_in beat);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        expected_results.push_back(predict_allocation(beat));
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Whole-heap exact fit, oversize requests, bad indices and freeing a free block
    task automatic test_whole_heap();
        send_command(make_command(CMD_ALLOC, 2044, 0));
        send_command(make_command(CMD_ALLOC, 0, 0));
        send_command(make_command(CMD_FREE, 0, 0));
        send_command(make_command(CMD_FREE, 0, 2));
        send_command(make_command(CMD_FREE, 2047, MAX_ITEM));
        send_command(make_command(CMD_FREE, 0, 1));
        send_command(make_command(CMD_ALLOC, 2047, MAX_ITEM));
    endtask

    // Splitting, exact fit into a hole, first-fit order and walk past the last block
    task automatic test_split_and_refit();
        send_command(make_command(CMD_ALLOC, 0, 0));
        send_command(make_command(CMD_ALLOC, 4, 0));
        send_command(make_command(CMD_ALLOC, 5, 0));
        send_command(make_command(CMD_ALLOC, 1024, 0));
        send_command(make_command(CMD_FREE, 0, 2));
        send_command(make_command(CMD_ALLOC, 3, 0));
        send_command(make_command(CMD_ALLOC, 2044, 0));
        send_command(make_command(CMD_FREE, 0, 0));
        send_command(make_command(CMD_FREE, 0, 256));
        send_command(make_command(CMD_ALLOC, 1, 0));
        send_command(make_command(CMD_FREE, 0, 4));
        send_command(make_command(CMD_ALLOC, 1020, 0));
        send_command(make_command(CMD_FREE, 0, 6));
        send_command(make_command(CMD_FREE, 0, 7));
    endtask

    // Random mix of allocations and frees under one idling pattern
    task automatic test_random_commands(input int n, input int idle_pct, input int stall_pct);
        t_in         beat;
        int unsigned pick;
        int unsigned nblocks;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) begin
            beat.request_bytes = 11'($urandom_range(0, 2047));
            beat.item_number   = 9'($urandom_range(0, MAX_ITEM));
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                beat.cmd = CMD_ALLOC;
                // mostly small requests so the heap keeps serving them
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    beat.request_bytes = 11'($urandom_range(0, 60));
                else if (pick < 85)
                    beat.request_bytes = 11'($urandom_range(0, 250));
            end else begin
                beat.cmd = CMD_FREE;
                nblocks = count_blocks();
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    beat.item_number = 9'($urandom_range(1, nblocks));
                else if (pick < 80)
                    beat.item_number = '0;
                else
                    beat.item_number = 9'($urandom_range(nblocks + 1, MAX_ITEM));
            end
            send_command(beat);
        end
        drain_results();
    endtask

    // Result checker: each accepted beat against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out want;
        t_out got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            got = o_out_data;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %p", $time, got);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, got.status);
                    fail_count++;
                end
                if (got.block_offset !== want.block_offset) begin
                    $display("%0t: block_offset mismatch, expected %0d, got %0d",
                             $time, want.block_offset, got.block_offset);
                    fail_count++;
                end
                if (got.block_size !== want.block_size) begin
                    $display("%0t: block_size mismatch, expected %0d, got %0d",
                             $time, want.block_size, got.block_size);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        foreach (heap_granules[g]) begin
            heap_granules[g] = 0;
            heap_used[g]     = 1'b0;
        end
        heap_granules[0] = HEAP_GRANULES;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_whole_heap();
        test_split_and_refit();
        drain_results();
        test_random_commands(PHASE_ITEMS, 0, 0);
        test_random_commands(PHASE_ITEMS, 48, 0);
        test_random_commands(PHASE_ITEMS, 0, 48);
        test_random_commands(PHASE_ITEMS, 38, 38);

        // catch any stray result after the last expected one
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
